// ----- src/irtag_pkg.sv -----
// Shared types and constants of the infrared pulse-width tag receiver.
package irtag_pkg;

  // Command codes carried in the request
  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_LOAD  = 2'd1,
    CMD_CLEAR = 2'd2
  } cmd_e;

  // Configuration register indexes
  localparam logic [2:0] REG_LONG_LO  = 3'd0;
  localparam logic [2:0] REG_LONG_HI  = 3'd1;
  localparam logic [2:0] REG_SHORT_LO = 3'd2;
  localparam logic [2:0] REG_SHORT_HI = 3'd3;
  localparam logic [2:0] REG_BIT_LO   = 3'd4;
  localparam logic [2:0] REG_BIT_HI   = 3'd5;
  localparam logic [2:0] REG_END      = 3'd6;
  localparam logic [2:0] REG_TAGLEN   = 3'd7;

  // Reset values of the configuration registers
  localparam logic [7:0] RST_LONG_LO  = 8'd45;
  localparam logic [7:0] RST_LONG_HI  = 8'd51;
  localparam logic [7:0] RST_SHORT_LO = 8'd21;
  localparam logic [7:0] RST_SHORT_HI = 8'd27;
  localparam logic [7:0] RST_BIT_LO   = 8'd5;
  localparam logic [7:0] RST_BIT_HI   = 8'd19;
  localparam logic [7:0] RST_END      = 8'd64;
  localparam logic [7:0] RST_TAGLEN   = 8'd17;

  // Pulse counts that select the header windows
  localparam logic [7:0] PULSE_LONG_STAGE = 8'd1;
  localparam logic [7:0] PULSE_BIT_STAGE  = 8'd3;

  typedef struct packed {
    logic [7:0] long_gap_low;
    logic [7:0] long_gap_high;
    logic [7:0] short_gap_low;
    logic [7:0] short_gap_high;
    logic [7:0] bit_gap_low;
    logic [7:0] bit_gap_high;
    logic [7:0] end_gap_limit;
    logic [7:0] tag_packet_length;
  } cfg_t;

  typedef struct packed {
    logic [1:0] cmd;
    logic       ir_level;
    logic [7:0] load_count;
  } req_t;

  typedef struct packed {
    logic       inhibit_out;
    logic [7:0] tags_left;
    logic       packet_end;
    logic       tag_seen;
  } res_t;

endpackage

// ----- src/ir_pulse_width_tag_receiver_core.sv -----
// Top level of the infrared pulse-width tag receiver.
//
// Each request is a tick with a line sample, a load of the tag counter or a
// clear of it, and gives exactly one result. A request is registered in the
// input register on acceptance, then decoded and applied to the receiver
// state as it moves into the output register, stalled while that register
// holds an untaken result. One request per cycle is sustained while results
// are taken, as the state update is a single registered step. The input
// register takes a new request whenever it is empty, or when the request it
// holds moves on to the output register in the same cycle. Configuration
// writes take effect on the next clock and are meant for idle periods.
module ir_pulse_width_tag_receiver_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [1:0] cmd_i,
  input  logic       ir_level_i,
  input  logic [7:0] load_count_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic       inhibit_out_o,
  output logic [7:0] tags_left_o,
  output logic       packet_end_o,
  output logic       tag_seen_o,
  input  logic       cfg_we_i,
  input  logic [2:0] cfg_index_i,
  input  logic [7:0] cfg_data_i
);
  import irtag_pkg::*;

  cfg_t cfg;
  req_t req_q;
  logic req_valid_q;
  res_t res, res_q;
  logic res_valid_q;
  logic res_load;
  logic in_take;

  irtag_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // Handshake: move the request when the output register can take it
  assign res_load   = req_valid_q && (!res_valid_q || out_ready_i);
  assign in_ready_o = !req_valid_q || res_load;
  assign in_take    = in_valid_i && in_ready_o;

  irtag_decoder u_dec (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (res_load),
    .req_i  (req_q),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  // Hold the accepted request
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      req_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      req_q.cmd        <= cmd_i;
      req_q.ir_level   <= ir_level_i;
      req_q.load_count <= load_count_i;
    end
  end

  // Hold the result until it is taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (res_load) begin
      res_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_load) begin
      res_q <= res;
    end
  end

  assign out_valid_o   = res_valid_q;
  assign inhibit_out_o = res_q.inhibit_out;
  assign tags_left_o   = res_q.tags_left;
  assign packet_end_o  = res_q.packet_end;
  assign tag_seen_o    = res_q.tag_seen;

endmodule

// ----- src/irtag_cfg_regs.sv -----
// Configuration register file of the tag receiver.
module irtag_cfg_regs (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [2:0]          cfg_index_i,
  input  logic [7:0]          cfg_data_i,
  output irtag_pkg::cfg_t     cfg_o
);
  import irtag_pkg::*;

  cfg_t cfg_q;

  // Write one register per enabled cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.long_gap_low      <= RST_LONG_LO;
      cfg_q.long_gap_high     <= RST_LONG_HI;
      cfg_q.short_gap_low     <= RST_SHORT_LO;
      cfg_q.short_gap_high    <= RST_SHORT_HI;
      cfg_q.bit_gap_low       <= RST_BIT_LO;
      cfg_q.bit_gap_high      <= RST_BIT_HI;
      cfg_q.end_gap_limit     <= RST_END;
      cfg_q.tag_packet_length <= RST_TAGLEN;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_LONG_LO:  cfg_q.long_gap_low      <= cfg_data_i;
        REG_LONG_HI:  cfg_q.long_gap_high     <= cfg_data_i;
        REG_SHORT_LO: cfg_q.short_gap_low     <= cfg_data_i;
        REG_SHORT_HI: cfg_q.short_gap_high    <= cfg_data_i;
        REG_BIT_LO:   cfg_q.bit_gap_low       <= cfg_data_i;
        REG_BIT_HI:   cfg_q.bit_gap_high      <= cfg_data_i;
        REG_END:      cfg_q.end_gap_limit     <= cfg_data_i;
        REG_TAGLEN:   cfg_q.tag_packet_length <= cfg_data_i;
        default:      cfg_q.tag_packet_length <= cfg_q.tag_packet_length;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ----- src/irtag_decoder.sv -----
// Pulse-width decoder state and per-request update logic.
module irtag_decoder (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_i,
  input  irtag_pkg::req_t     req_i,
  input  irtag_pkg::cfg_t     cfg_i,
  output irtag_pkg::res_t     res_o
);
  import irtag_pkg::*;

  logic       prev_level_q, prev_level_d;
  logic [7:0] gap_ticks_q, gap_ticks_d;
  logic [7:0] pulse_count_q, pulse_count_d;
  logic [7:0] loaded_tags_q, loaded_tags_d;
  logic       inhibit_q, inhibit_d;

  logic [7:0] win_lo, win_hi;
  logic       win_ok;
  logic [7:0] gap_inc;
  logic       gap_over;
  logic       tag_match;
  logic [7:0] tags_dec;
  logic       ended, tag;

  // Pick the interval window for the current stage
  always_comb begin
    priority if (pulse_count_q == PULSE_LONG_STAGE) begin
      win_lo = cfg_i.long_gap_low;
      win_hi = cfg_i.long_gap_high;
    end else if (pulse_count_q < PULSE_BIT_STAGE) begin
      win_lo = cfg_i.short_gap_low;
      win_hi = cfg_i.short_gap_high;
    end else begin
      win_lo = cfg_i.bit_gap_low;
      win_hi = cfg_i.bit_gap_high;
    end
  end

  assign win_ok    = (gap_ticks_q > win_lo) && (gap_ticks_q < win_hi);
  assign gap_inc   = gap_ticks_q + 8'd1;
  assign gap_over  = gap_inc > cfg_i.end_gap_limit;
  assign tag_match = pulse_count_q == cfg_i.tag_packet_length;
  assign tags_dec  = (loaded_tags_q != 8'd0) ? loaded_tags_q - 8'd1 : 8'd0;

  // Compute next state for the request
  always_comb begin
    prev_level_d  = prev_level_q;
    gap_ticks_d   = gap_ticks_q;
    pulse_count_d = pulse_count_q;
    loaded_tags_d = loaded_tags_q;
    inhibit_d     = inhibit_q;
    ended         = 1'b0;
    tag           = 1'b0;
    unique case (req_i.cmd)
      CMD_TICK: begin
        prev_level_d = req_i.ir_level;
        if (req_i.ir_level != prev_level_q) begin
          // Edge: check the interval, restart the gap count
          if (win_ok) begin
            pulse_count_d = pulse_count_q + 8'd1;
          end
          gap_ticks_d = 8'd0;
        end else if (gap_over) begin
          // Quiet too long: close the packet
          ended         = 1'b1;
          pulse_count_d = 8'd0;
          gap_ticks_d   = 8'd0;
          if (tag_match) begin
            tag           = 1'b1;
            loaded_tags_d = tags_dec;
            if (tags_dec == 8'd0) begin
              inhibit_d = 1'b0;
            end
          end
        end else begin
          gap_ticks_d = gap_inc;
        end
      end
      CMD_LOAD: begin
        loaded_tags_d = req_i.load_count;
        inhibit_d     = 1'b1;
      end
      CMD_CLEAR: begin
        loaded_tags_d = 8'd0;
        inhibit_d     = 1'b0;
      end
      default: begin
        inhibit_d = inhibit_q;
      end
    endcase
  end

  // Advance state when a request is processed
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_level_q  <= 1'b0;
      gap_ticks_q   <= 8'd0;
      pulse_count_q <= 8'd0;
      loaded_tags_q <= 8'd0;
      inhibit_q     <= 1'b0;
    end else if (step_i) begin
      prev_level_q  <= prev_level_d;
      gap_ticks_q   <= gap_ticks_d;
      pulse_count_q <= pulse_count_d;
      loaded_tags_q <= loaded_tags_d;
      inhibit_q     <= inhibit_d;
    end
  end

  assign res_o.inhibit_out = inhibit_d;
  assign res_o.tags_left   = loaded_tags_d;
  assign res_o.packet_end  = ended;
  assign res_o.tag_seen    = tag;

endmodule

// ----- test/ir_pulse_width_tag_receiver_core_tb.sv -----
// Testbench of the IR pulse-width tag receiver core: directed table, packets, predicted results.
`timescale 1ns / 100ps

module ir_pulse_width_tag_receiver_core_tb;
  import irtag_pkg::*;

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int ITEM_TARGET = 1300;
  localparam int GAP_CAP = 60;
  localparam int IDLE_SETTLE = 4;
  localparam int LIMIT_NS = 1_000_000;

  typedef enum logic {ROW_REQ, ROW_CFG} row_kind_e;

  typedef struct packed {
    row_kind_e  kind;
    logic [1:0] cmd;
    logic [2:0] reg_idx;
    logic       level;
    logic [7:0] value;
    logic       pinned;
    res_t       want;
  } row_t;

  // Directed table: requests with their result typed in where obvious, and register writes
  localparam row_t DIRECTED [22] = '{
    '{ROW_REQ, CMD_TICK,   '0,         1'b0, 8'd0,   1'b1, '{1'b0, 8'd0,   1'b0, 1'b0}},
    '{ROW_REQ, CMD_LOAD,   '0,         1'b0, 8'd255, 1'b1, '{1'b1, 8'd255, 1'b0, 1'b0}},
    '{ROW_REQ, CMD_LOAD,   '0,         1'b1, 8'd0,   1'b1, '{1'b1, 8'd0,   1'b0, 1'b0}},
    '{ROW_REQ, CMD_CLEAR,  '0,         1'b1, 8'hAA,  1'b1, '{1'b0, 8'd0,   1'b0, 1'b0}},
    '{ROW_REQ, CMD_UNUSED, '0,         1'b1, 8'd255, 1'b1, '{1'b0, 8'd0,   1'b0, 1'b0}},
    '{ROW_REQ, CMD_LOAD,   '0,         1'b0, 8'd2,   1'b1, '{1'b1, 8'd2,   1'b0, 1'b0}},
    '{ROW_CFG, CMD_TICK,   REG_END,    1'b0, 8'd0,   1'b0, '0},
    '{ROW_CFG, CMD_TICK,   REG_TAGLEN, 1'b0, 8'd0,   1'b0, '0},
    '{ROW_REQ, CMD_TICK,   '0,         1'b0, 8'd0,   1'b1, '{1'b1, 8'd1,   1'b1, 1'b1}},
    '{ROW_REQ, CMD_TICK,   '0,         1'b0, 8'd0,   1'b1, '{1'b0, 8'd0,   1'b1, 1'b1}},
    '{ROW_REQ, CMD_TICK,   '0,         1'b0, 8'hFF,  1'b1, '{1'b0, 8'd0,   1'b1, 1'b1}},
    '{ROW_REQ, CMD_TICK,   '0,         1'b1, 8'd0,   1'b1, '{1'b0, 8'd0,   1'b0, 1'b0}},
    '{ROW_REQ, CMD_TICK,   '0,         1'b1, 8'd0,   1'b1, '{1'b0, 8'd0,   1'b1, 1'b1}},
    '{ROW_CFG, CMD_TICK,   REG_TAGLEN, 1'b0, 8'd255, 1'b0, '0},
    '{ROW_CFG, CMD_TICK,   REG_END,    1'b0, 8'd254, 1'b0, '0},
    '{ROW_CFG, CMD_TICK,   REG_SHORT_LO, 1'b0, 8'd0, 1'b0, '0},
    '{ROW_CFG, CMD_TICK,   REG_SHORT_HI, 1'b0, 8'd255, 1'b0, '0},
    '{ROW_REQ, CMD_TICK,   '0,         1'b1, 8'd0,   1'b0, '0},
    '{ROW_REQ, CMD_TICK,   '0,         1'b0, 8'd0,   1'b0, '0},
    '{ROW_REQ, CMD_LOAD,   '0,         1'b0, 8'h55,  1'b1, '{1'b1, 8'h55,  1'b0, 1'b0}},
    '{ROW_REQ, CMD_TICK,   '0,         1'b1, 8'd0,   1'b0, '0},
    '{ROW_REQ, CMD_CLEAR,  '0,         1'b0, 8'd0,   1'b1, '{1'b0, 8'd0,   1'b0, 1'b0}}
  };

  logic       clk;
  logic       rst_n;
  logic       req_valid;
  logic       req_ready;
  logic [1:0] req_cmd;
  logic       req_level;
  logic [7:0] req_load;
  logic       res_valid;
  logic       res_ready;
  logic       res_inhibit;
  logic [7:0] res_tags;
  logic       res_end;
  logic       res_tag;
  logic       cfg_we;
  logic [2:0] cfg_index;
  logic [7:0] cfg_data;

  // Shadow of the receiver: configuration and state
  cfg_t win = '{RST_LONG_LO, RST_LONG_HI, RST_SHORT_LO, RST_SHORT_HI,
                RST_BIT_LO, RST_BIT_HI, RST_END, RST_TAGLEN};
  logic       line_q = 1'b0;
  logic [7:0] quiet_ticks = '0;
  logic [7:0] pulse_cnt = '0;
  logic [7:0] tags_loaded = '0;
  logic       inhibit_q = 1'b0;

  res_t pending_results[$];
  bit   pin_on = 1'b0;
  res_t pin_res = '0;
  bit   tx_steady = 1'b0;
  bit   rx_steady = 1'b0;
  int   res_hold = 0;
  int   fail_cnt = 0;
  int   item_cnt = 0;
  logic line_drive = 1'b0;

  ir_pulse_width_tag_receiver_core dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (req_valid),
    .in_ready_o    (req_ready),
    .cmd_i         (req_cmd),
    .ir_level_i    (req_level),
    .load_count_i  (req_load),
    .out_valid_o   (res_valid),
    .out_ready_i   (res_ready),
    .inhibit_out_o (res_inhibit),
    .tags_left_o   (res_tags),
    .packet_end_o  (res_end),
    .tag_seen_o    (res_tag),
    .cfg_we_i      (cfg_we),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #(LIMIT_NS);
    $display("tb: failure");
    $finish;
  end

  function automatic logic in_span(logic [7:0] v, logic [7:0] lo, logic [7:0] hi);
    return (v > lo) && (v < hi);
  endfunction

  // Apply one request to the shadow state and return the result it gives
  function automatic res_t advance_receiver(logic [1:0] c, logic lvl, logic [7:0] ld);
    res_t r;
    logic hit;
    r = '0;
    case (c)
      CMD_TICK: begin
        if (lvl != line_q) begin
          if (pulse_cnt == PULSE_LONG_STAGE)
            hit = in_span(quiet_ticks, win.long_gap_low, win.long_gap_high);
          else if (pulse_cnt < PULSE_BIT_STAGE)
            hit = in_span(quiet_ticks, win.short_gap_low, win.short_gap_high);
          else
            hit = in_span(quiet_ticks, win.bit_gap_low, win.bit_gap_high);
          if (hit) pulse_cnt = pulse_cnt + 8'd1;
          quiet_ticks = '0;
        end else begin
          quiet_ticks = quiet_ticks + 8'd1;
          if (quiet_ticks > win.end_gap_limit) begin
            r.packet_end = 1'b1;
            if (pulse_cnt == win.tag_packet_length) begin
              r.tag_seen = 1'b1;
              if (tags_loaded != '0) tags_loaded = tags_loaded - 8'd1;
              if (tags_loaded == '0) inhibit_q = 1'b0;
            end
            pulse_cnt = '0;
            quiet_ticks = '0;
          end
        end
        line_q = lvl;
      end
      CMD_LOAD: begin
        tags_loaded = ld;
        inhibit_q = 1'b1;
      end
      CMD_CLEAR: begin
        tags_loaded = '0;
        inhibit_q = 1'b0;
      end
      default: ;
    endcase
    r.inhibit_out = inhibit_q;
    r.tags_left = tags_loaded;
    return r;
  endfunction

  function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $display("%0t mismatch on %s: expected %0d, got %0d", $time, name, want, got);
      fail_cnt++;
    end
  endfunction

  // Track register writes, predict accepted requests, check delivered results
  always @(posedge clk) begin : result_check
    res_t got;
    res_t want;
    if (rst_n) begin
      if (cfg_we) begin
        case (cfg_index)
          REG_LONG_LO:  win.long_gap_low = cfg_data;
          REG_LONG_HI:  win.long_gap_high = cfg_data;
          REG_SHORT_LO: win.short_gap_low = cfg_data;
          REG_SHORT_HI: win.short_gap_high = cfg_data;
          REG_BIT_LO:   win.bit_gap_low = cfg_data;
          REG_BIT_HI:   win.bit_gap_high = cfg_data;
          REG_END:      win.end_gap_limit = cfg_data;
          REG_TAGLEN:   win.tag_packet_length = cfg_data;
          default: ;
        endcase
      end
      if (req_valid && req_ready) begin
        want = advance_receiver(req_cmd, req_level, req_load);
        if (pin_on) want = pin_res;
        pending_results.push_back(want);
      end
      if (res_valid && res_ready) begin
        got = '{res_inhibit, res_tags, res_end, res_tag};
        if (pending_results.size() == 0) begin
          $display("%0t unexpected result: expected none, got %h", $time, got);
          fail_cnt++;
        end else begin
          want = pending_results.pop_front();
          check_field("inhibit_out", 8'(want.inhibit_out), 8'(got.inhibit_out));
          check_field("tags_left", want.tags_left, got.tags_left);
          check_field("packet_end", 8'(want.packet_end), 8'(got.packet_end));
          check_field("tag_seen", 8'(want.tag_seen), 8'(got.tag_seen));
        end
        res_hold = rx_steady ? 0 : $urandom_range(0, 16);
      end
    end
  end

  // Result side: stall after each result while the drawn hold count runs down
  initial begin
    res_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (res_hold != 0) begin
        res_ready <= 1'b0;
        res_hold--;
      end else begin
        res_ready <= 1'b1;
      end
    end
  end

  // Send one request; called and returning at a falling edge
  task automatic send_request(input logic [1:0] c, input logic lvl, input logic [7:0] ld,
                              input bit pin = 1'b0, input res_t want = '0);
    int gap;
    gap = tx_steady ? 0 : $urandom_range(0, 16);
    if (gap != 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_valid <= 1'b1;
    req_cmd <= c;
    req_level <= lvl;
    req_load <= ld;
    pin_on = pin;
    pin_res = want;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    if (c != CMD_UNUSED) item_cnt++;
    @(negedge clk);
  endtask

  task automatic send_tick(input logic lvl);
    send_request(CMD_TICK, lvl, 8'($urandom));
  endtask

  // Hold requests until every result is back and the block is quiet
  task automatic drain_requests();
    req_valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (IDLE_SETTLE) @(negedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [7:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic program_config(input cfg_t c);
    drain_requests();
    write_reg(REG_LONG_LO, c.long_gap_low);
    write_reg(REG_LONG_HI, c.long_gap_high);
    write_reg(REG_SHORT_LO, c.short_gap_low);
    write_reg(REG_SHORT_HI, c.short_gap_high);
    write_reg(REG_BIT_LO, c.bit_gap_low);
    write_reg(REG_BIT_HI, c.bit_gap_high);
    write_reg(REG_END, c.end_gap_limit);
    write_reg(REG_TAGLEN, c.tag_packet_length);
  endtask

  // Quiet ticks before the edge of pulse p: mostly inside its window, now and then off
  function automatic int pick_gap(int p);
    int lo, hi, lim, g;
    if (p == int'(PULSE_LONG_STAGE)) begin
      lo = int'(win.long_gap_low);
      hi = int'(win.long_gap_high);
    end else if (p < int'(PULSE_BIT_STAGE)) begin
      lo = int'(win.short_gap_low);
      hi = int'(win.short_gap_high);
    end else begin
      lo = int'(win.bit_gap_low);
      hi = int'(win.bit_gap_high);
    end
    lim = (int'(win.end_gap_limit) < GAP_CAP) ? int'(win.end_gap_limit) : GAP_CAP;
    if (hi > lo + 1 && lo < lim && $urandom_range(0, 9) != 0) begin
      g = lo + 1 + $urandom_range(0, 2);
      if (g > hi - 1) g = hi - 1;
      if (g > lim) g = lim;
    end else begin
      case ($urandom_range(0, 2))
        0: g = lo;
        1: g = hi;
        default: g = $urandom_range(0, lim);
      endcase
      if (g > GAP_CAP) g = GAP_CAP;
    end
    return g;
  endfunction

  // Random request of any kind, the unused command and stray edges among them
  task automatic send_noise();
    case ($urandom_range(0, 5))
      0: send_request(CMD_LOAD, 1'($urandom), 8'($urandom));
      1: send_request(CMD_CLEAR, 1'($urandom), 8'($urandom));
      2: send_request(CMD_UNUSED, 1'($urandom), 8'($urandom));
      default: begin
        line_drive = 1'($urandom);
        send_tick(line_drive);
      end
    endcase
  endtask

  // Send one packet: pulses with their gaps, then quiet until it closes
  task automatic send_packet(input int pulses);
    int g;
    for (int p = 0; p < pulses; p++) begin
      g = pick_gap(p);
      repeat (g) send_tick(line_drive);
      line_drive = ~line_drive;
      send_tick(line_drive);
      if ($urandom_range(0, 24) == 0) send_noise();
    end
    repeat (int'(win.end_gap_limit) + 1) send_tick(line_drive);
  endtask

  // Tag loads, clears and noise between packets
  task automatic send_side_traffic();
    case ($urandom_range(0, 5))
      0: send_request(CMD_LOAD, line_drive, 8'($urandom_range(0, 3)));
      1: send_request(CMD_LOAD, line_drive, 8'($urandom));
      2: send_request(CMD_CLEAR, line_drive, 8'($urandom));
      3: repeat ($urandom_range(1, 6)) send_noise();
      default: ;
    endcase
  endtask

  initial begin : stimulus
    row_t row;
    cfg_t c;
    int top;
    int pulses;
    rst_n = 1'b0;
    req_valid = 1'b0;
    req_cmd = CMD_TICK;
    req_level = 1'b0;
    req_load = '0;
    cfg_we = 1'b0;
    cfg_index = REG_LONG_LO;
    cfg_data = '0;
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Walk the directed table
    for (int i = 0; i < $size(DIRECTED); i++) begin
      row = DIRECTED[i];
      if (row.kind == ROW_CFG) begin
        drain_requests();
        write_reg(row.reg_idx, row.value);
      end else begin
        if (row.cmd == CMD_TICK) line_drive = row.level;
        send_request(row.cmd, row.level, row.value, row.pinned, row.want);
      end
    end

    // Reset windows: one full-length tag packet with tags loaded
    program_config('{RST_LONG_LO, RST_LONG_HI, RST_SHORT_LO, RST_SHORT_HI,
                     RST_BIT_LO, RST_BIT_HI, RST_END, RST_TAGLEN});
    send_request(CMD_LOAD, line_drive, 8'($urandom_range(1, 3)));
    send_packet(int'(RST_TAGLEN));

    // Open windows: close any packet with a zero end limit, then wrap the pulse count
    // and the quiet counter with the end limit at its maximum
    program_config('{8'd0, 8'd255, 8'd0, 8'd255, 8'd0, 8'd255, 8'd0, 8'd4});
    send_tick(line_drive);
    drain_requests();
    write_reg(REG_END, 8'd255);
    send_request(CMD_LOAD, line_drive, 8'd1);
    repeat (260) begin
      send_tick(line_drive);
      line_drive = ~line_drive;
      send_tick(line_drive);
    end
    repeat (257) send_tick(line_drive);
    drain_requests();
    write_reg(REG_END, 8'd3);
    repeat (4) send_tick(line_drive);

    // Highest end limit that still closes packets
    program_config('{8'd0, 8'd255, 8'd0, 8'd255, 8'd0, 8'd255, 8'd254, 8'd2});
    send_request(CMD_LOAD, line_drive, 8'd2);
    send_packet(2);

    // Random phases: mostly narrow windows, some with every window shut
    do begin
      if ($urandom_range(0, 5) == 0) begin
        c = '{8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'($urandom_range(0, 3)), 8'h00};
      end else begin
        c.short_gap_low = 8'($urandom_range(0, 3));
        c.short_gap_high = c.short_gap_low + 8'($urandom_range(2, 4));
        c.long_gap_low = 8'($urandom_range(2, 6));
        c.long_gap_high = c.long_gap_low + 8'($urandom_range(2, 4));
        c.bit_gap_low = 8'($urandom_range(0, 2));
        c.bit_gap_high = c.bit_gap_low + 8'($urandom_range(2, 4));
        top = int'(c.long_gap_high);
        if (int'(c.short_gap_high) > top) top = int'(c.short_gap_high);
        if (int'(c.bit_gap_high) > top) top = int'(c.bit_gap_high);
        c.end_gap_limit = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 4))
                                                       : 8'(top - 1 + $urandom_range(0, 3));
        c.tag_packet_length = 8'($urandom_range(0, 8));
      end
      program_config(c);
      repeat ($urandom_range(3, 6)) begin
        tx_steady = ($urandom_range(0, 3) == 0);
        rx_steady = ($urandom_range(0, 3) == 0);
        send_side_traffic();
        pulses = ($urandom_range(0, 3) != 0) ? int'(win.tag_packet_length)
                                             : $urandom_range(0, 10);
        send_packet(pulses);
        if ($urandom_range(0, 9) == 0) drain_requests();
      end
    end while (item_cnt < ITEM_TARGET);

    // Let the last results come back
    drain_requests();
    repeat (8) @(posedge clk);
    if (fail_cnt == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ----- files.f -----
src/irtag_pkg.sv
src/irtag_cfg_regs.sv
src/irtag_decoder.sv
src/ir_pulse_width_tag_receiver_core.sv
test/ir_pulse_width_tag_receiver_core_tb.sv
